### rtl/core/fmd_pkg.sv
// Shared package of the FM discriminator core: default sizes, output limits,
// sequencer codes and the control structs passed between the core's modules.
// No dependencies.
`default_nettype none

package fmd_pkg;

  // Defaults for the top-level parameters.
  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int OUT_FRAC_BITS_DEF = 12;

  // The output field is fixed at 16 bits, signed.
  localparam int OUT_W = 16;

  // The divider produces one bit more than the output so that any quotient
  // of 65536 or more shows up as an overflow bit.
  localparam int QUO_W     = OUT_W + 1;
  localparam int DIV_STEPS = QUO_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Clamp levels of the quotient magnitude for each sign.
  localparam logic [QUO_W-1:0] OUT_MAX_POS = QUO_W'(32767);
  localparam logic [QUO_W-1:0] OUT_MAX_NEG = QUO_W'(32768);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_FIN
  } fmd_state_t;

  // Order in which the four products go through the shared multiplier.
  typedef enum logic [2:0] {
    MS_QPI,
    MS_IPQ,
    MS_II,
    MS_QQ,
    MS_DONE
  } mul_step_t;

  typedef struct packed {
    logic      valid;
    mul_step_t step;
  } mul_tag_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

`default_nettype wire

### rtl/core/fmd_in_if.sv
// Input stream interface of the FM discriminator core: one I/Q pair per beat.
// Depends on fmd_pkg for the default sample width.
`default_nettype none

interface fmd_in_if #(
  parameter int SAMPLE_WIDTH = fmd_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] i_sample;
  logic signed [SAMPLE_WIDTH-1:0] q_sample;

  modport source (output valid, output i_sample, output q_sample, input ready);
  modport sink   (input valid, input i_sample, input q_sample, output ready);
endinterface

`default_nettype wire

### rtl/core/fmd_out_if.sv
// Result stream interface of the FM discriminator core: one value per beat.
// Depends on fmd_pkg for the output width.
`default_nettype none

interface fmd_out_if ();
  logic                           valid;
  logic                           ready;
  logic signed [fmd_pkg::OUT_W-1:0] demod_value;
  logic                           saturated;

  modport source (output valid, output demod_value, output saturated, input ready);
  modport sink   (input valid, input demod_value, input saturated, output ready);
endinterface

`default_nettype wire

### rtl/core/fmd_mul.sv
// Shared signed multiplier of the FM discriminator core, one registered
// product per cycle with its step tag. Depends on fmd_pkg.
`default_nettype none

module fmd_mul #(
  parameter int SAMPLE_WIDTH = fmd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fmd_pkg::mul_tag_t                req,
  input  logic signed [SAMPLE_WIDTH-1:0]   op_a,
  input  logic signed [SAMPLE_WIDTH-1:0]   op_b,
  output fmd_pkg::mul_tag_t                rsp,
  output logic signed [2*SAMPLE_WIDTH-1:0] prod
);

  fmd_pkg::mul_tag_t                rsp_r;
  logic signed [2*SAMPLE_WIDTH-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_r <= '{valid: 1'b0, step: fmd_pkg::MS_QPI};
    end else begin
      rsp_r <= req;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign rsp  = rsp_r;
  assign prod = prod_r;

endmodule

`default_nettype wire

### rtl/core/fmd_div.sv
// Restoring divider of the FM discriminator core, one quotient bit per cycle,
// giving floor(num * 2^OUT_FRAC_BITS / den) with an overflow bit. Depends on fmd_pkg.
`default_nettype none

module fmd_div #(
  parameter int SAMPLE_WIDTH  = fmd_pkg::SAMPLE_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = fmd_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fmd_pkg::div_ctl_t           ctl,
  input  logic [2*SAMPLE_WIDTH-1:0]   num_mag,
  input  logic [2*SAMPLE_WIDTH-1:0]   den,
  output fmd_pkg::div_stat_t          stat,
  output logic [fmd_pkg::OUT_W-1:0]   quo
);

  localparam int PW = 2 * SAMPLE_WIDTH;
  localparam int CW = PW + fmd_pkg::QUO_W;

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [fmd_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]                  rem_r, rem_nxt;
  logic [CW-1:0]                  dsh_r, dsh_nxt;
  logic [fmd_pkg::QUO_W-1:0]      quo_r, quo_nxt;
  logic [CW:0]                    diff;
  logic                           fits;

  // The remainder starts as the numerator scaled by the fraction bits and the
  // divisor starts at den << 16; it moves right one place each step.
  assign diff = {1'b0, rem_r} - {1'b0, dsh_r};
  assign fits = !diff[CW];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = fmd_pkg::DIV_CNT_W'(fmd_pkg::DIV_STEPS);
      rem_nxt  = {{(CW-PW-OUT_FRAC_BITS){1'b0}}, num_mag, {OUT_FRAC_BITS{1'b0}}};
      dsh_nxt  = {1'b0, den, {(fmd_pkg::QUO_W-1){1'b0}}};
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = diff[CW-1:0];
      end
      quo_nxt = {quo_r[fmd_pkg::QUO_W-2:0], fits};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - fmd_pkg::DIV_CNT_W'(1);
      if (cnt_r == fmd_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.done = done_r;
  assign stat.ovf  = quo_r[fmd_pkg::QUO_W-1];
  assign quo       = quo_r[fmd_pkg::OUT_W-1:0];

endmodule

`default_nettype wire

### rtl/core/fm_discriminator_core.sv
// Top level of the FM discriminator core: sequencer, sample state and output
// register around the shared multiplier and the bit-serial divider.
// Depends on fmd_pkg, fmd_in_if, fmd_out_if, fmd_mul and fmd_div.
//
//   Channel  Dir  Beat contents                      Handshake
//   in_ch    in   i_sample, q_sample (signed Q1.15)  valid/ready
//   out_ch   out  demod_value (Q4.12), saturated     valid/ready
//
// A pair goes through the shared multiplier for four products, then the divider is
// started, runs its 17 division steps and raises its done flag, and the result is
// loaded into the output register; a pair with a zero I or Q goes from acceptance
// straight to the load. The core takes a new pair only after the last one is loaded.
// Reset is synchronous and clears the previous sample; in_ch.ready is high only in
// idle. A stalled result holds the output register; only the next load waits.
`default_nettype none

module fm_discriminator_core #(
  parameter int SAMPLE_WIDTH  = fmd_pkg::SAMPLE_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = fmd_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fmd_in_if.sink     in_ch,
  fmd_out_if.source  out_ch
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int PW = 2 * SW;
  localparam int NW = PW + 1;

  fmd_pkg::fmd_state_t state_r, state_nxt;
  fmd_pkg::mul_step_t  step_r, step_nxt;

  // Sample state and working operands of the pair in flight.
  logic signed [SW-1:0] prev_i_r, prev_q_r;
  logic signed [SW-1:0] cur_i_r, cur_q_r;
  logic signed [SW-1:0] opi_r, opq_r;
  logic                 zero_r;

  // Numerator q*pi - i*pq and denominator i*i + q*q.
  logic signed [NW-1:0] num_r;
  logic        [PW-1:0] den_r;
  logic signed [NW-1:0] num_neg;
  logic        [PW-1:0] num_mag;

  // Output register.
  logic                           out_valid_r;
  logic signed [fmd_pkg::OUT_W-1:0] out_val_r;
  logic                           out_sat_r;

  fmd_pkg::mul_tag_t    mul_req, mul_rsp;
  logic signed [SW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_prod;

  fmd_pkg::div_ctl_t            div_ctl;
  fmd_pkg::div_stat_t           div_stat;
  logic [fmd_pkg::OUT_W-1:0]    div_quo;

  logic                         in_fire;
  logic                         out_free;
  logic                         zero_in;

  // Final saturation and sign of the quotient.
  logic [fmd_pkg::QUO_W-1:0]    mag_full;
  logic [fmd_pkg::QUO_W-1:0]    limit;
  logic [fmd_pkg::QUO_W-1:0]    mag_clip;
  logic [fmd_pkg::QUO_W-1:0]    mag_signed;
  logic                         fin_sat;
  logic [fmd_pkg::OUT_W-1:0]    fin_val;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign zero_in  = (in_ch.i_sample == '0) || (in_ch.q_sample == '0);

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fmd_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = zero_in ? fmd_pkg::ST_FIN : fmd_pkg::ST_MUL;
        end
      end
      fmd_pkg::ST_MUL: begin
        if (mul_rsp.valid && (mul_rsp.step == fmd_pkg::MS_QQ)) begin
          state_nxt = fmd_pkg::ST_DSTART;
        end
      end
      fmd_pkg::ST_DSTART: begin
        state_nxt = fmd_pkg::ST_DIV;
      end
      fmd_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = fmd_pkg::ST_FIN;
        end
      end
      fmd_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = fmd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fmd_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs: input ready, multiplier issue and divider start.
  always_comb begin
    in_ch.ready   = 1'b0;
    mul_req.valid = 1'b0;
    mul_req.step  = step_r;
    div_ctl.start = 1'b0;
    step_nxt      = step_r;
    case (state_r)
      fmd_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        step_nxt    = fmd_pkg::MS_QPI;
      end
      fmd_pkg::ST_MUL: begin
        case (step_r)
          fmd_pkg::MS_QPI: begin
            mul_req.valid = 1'b1;
            step_nxt      = fmd_pkg::MS_IPQ;
          end
          fmd_pkg::MS_IPQ: begin
            mul_req.valid = 1'b1;
            step_nxt      = fmd_pkg::MS_II;
          end
          fmd_pkg::MS_II: begin
            mul_req.valid = 1'b1;
            step_nxt      = fmd_pkg::MS_QQ;
          end
          fmd_pkg::MS_QQ: begin
            mul_req.valid = 1'b1;
            step_nxt      = fmd_pkg::MS_DONE;
          end
          default: begin
            step_nxt = fmd_pkg::MS_DONE;
          end
        endcase
      end
      fmd_pkg::ST_DSTART: begin
        div_ctl.start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Operand select for the shared multiplier.
  always_comb begin
    case (step_r)
      fmd_pkg::MS_QPI: begin
        mul_a = cur_q_r;
        mul_b = opi_r;
      end
      fmd_pkg::MS_IPQ: begin
        mul_a = cur_i_r;
        mul_b = opq_r;
      end
      fmd_pkg::MS_II: begin
        mul_a = cur_i_r;
        mul_b = cur_i_r;
      end
      default: begin
        mul_a = cur_q_r;
        mul_b = cur_q_r;
      end
    endcase
  end

  fmd_mul #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .rsp   (mul_rsp),
    .prod  (mul_prod)
  );

  // The divider works on magnitudes; the sign is applied at the end.
  assign num_neg = -num_r;
  assign num_mag = num_r[NW-1] ? num_neg[PW-1:0] : num_r[PW-1:0];

  fmd_div #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (div_ctl),
    .num_mag (num_mag),
    .den     (den_r),
    .stat    (div_stat),
    .quo     (div_quo)
  );

  // Clamp to 32767 for a positive and 32768 for a negative result, then
  // negate a negative one. A zero I or Q forces a plain zero without saturation.
  assign mag_full   = {div_stat.ovf, div_quo};
  assign limit      = num_r[NW-1] ? fmd_pkg::OUT_MAX_NEG : fmd_pkg::OUT_MAX_POS;
  assign fin_sat    = !zero_r && (mag_full > limit);
  assign mag_clip   = (mag_full > limit) ? limit : mag_full;
  assign mag_signed = num_r[NW-1] ? -mag_clip : mag_clip;
  assign fin_val    = zero_r ? '0 : mag_signed[fmd_pkg::OUT_W-1:0];

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fmd_pkg::ST_IDLE;
      step_r      <= fmd_pkg::MS_QPI;
      prev_i_r    <= '0;
      prev_q_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (in_fire) begin
        prev_i_r <= in_ch.i_sample;
        prev_q_r <= in_ch.q_sample;
      end
      if ((state_r == fmd_pkg::ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_i_r <= in_ch.i_sample;
      cur_q_r <= in_ch.q_sample;
      opi_r   <= prev_i_r;
      opq_r   <= prev_q_r;
      zero_r  <= zero_in;
    end
    if (mul_rsp.valid) begin
      case (mul_rsp.step)
        fmd_pkg::MS_QPI: num_r <= {mul_prod[PW-1], mul_prod};
        fmd_pkg::MS_IPQ: num_r <= num_r - {mul_prod[PW-1], mul_prod};
        fmd_pkg::MS_II:  den_r <= mul_prod[PW-1:0];
        fmd_pkg::MS_QQ:  den_r <= den_r + mul_prod[PW-1:0];
        default: begin
        end
      endcase
    end
    if ((state_r == fmd_pkg::ST_FIN) && out_free) begin
      out_val_r <= fin_val;
      out_sat_r <= fin_sat;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.demod_value = out_val_r;
  assign out_ch.saturated   = out_sat_r;

endmodule

`default_nettype wire

### rtl/core/fmd_checker.sv
// Port-level checker of the FM discriminator core and its bind to the top level.
// Depends on fmd_pkg and on the ports of fm_discriminator_core.
`default_nettype none

module fmd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [fmd_pkg::OUT_W-1:0] out_demod_value,
  input logic                             out_saturated
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_demod_value)
      && $stable(out_saturated))
    else $error("result beat changed while stalled");

  // The core works on one pair at a time: no second beat right after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted beat");

  // A new result is only loaded while the sequencer is busy.
  a_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the core was idle");

  // A clipped result sits exactly at one of the range ends.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> (out_demod_value == 16'sh7fff)
      || (out_demod_value == -16'sh8000))
    else $error("saturated flag with a value inside the range");

endmodule

bind fm_discriminator_core fmd_checker u_fmd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_demod_value (out_ch.demod_value),
  .out_saturated   (out_ch.saturated)
);

`default_nettype wire

### test/tb_fm_discriminator_core.sv
// Self-checking testbench for fm_discriminator_core: directed and random I/Q beats
// with random idling on both channels. A scoreboard class predicts each result.
// Depends on fmd_pkg, fmd_in_if, fmd_out_if and the core itself.
`default_nettype none

module tb_fm_discriminator_core;

  localparam int SW              = fmd_pkg::SAMPLE_WIDTH_DEF;
  localparam int FRAC            = fmd_pkg::OUT_FRAC_BITS_DEF;
  localparam int OUT_W           = fmd_pkg::OUT_W;
  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 9;
  localparam int PHASE_ITEMS     = 380;
  localparam int HOLDOFF_CYCLES  = 300;
  localparam int MAX_REPORTS     = 10;
  localparam int SETTLE_CYCLES   = 40;
  localparam int TIMEOUT_CYCLES  = 600_000;

  typedef logic signed [SW-1:0] sample_t;

  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    sat;
    sample_t                 i_s;
    sample_t                 q_s;
  } demod_t;

  // Keeps its own copy of the previous I/Q pair and a queue of predicted
  // discriminator values, oldest first.
  class demod_scoreboard;
    demod_t  want_q[$];
    sample_t last_i;
    sample_t last_q;
    int      mismatches;

    function new();
      last_i     = '0;
      last_q     = '0;
      mismatches = 0;
    endfunction

    // The numerator reduces to Q*Ip - I*Qp. The quotient magnitude is taken
    // with FRAC fraction bits, truncated, then clamped per sign.
    function void note_pair(sample_t i_s, sample_t q_s);
      longint          ci, cq, pi, pq, num;
      longint unsigned mag, den, quo, lim;
      demod_t          want;
      ci = longint'(i_s);
      cq = longint'(q_s);
      pi = longint'(last_i);
      pq = longint'(last_q);
      last_i     = i_s;
      last_q     = q_s;
      want.value = '0;
      want.sat   = 1'b0;
      want.i_s   = i_s;
      want.q_s   = q_s;
      // A zero component forces a zero result, which also covers a zero denominator.
      if (ci != 0 && cq != 0) begin
        num = cq * pi - ci * pq;
        mag = (num < 0) ? -num : num;
        den = ci * ci + cq * cq;
        quo = (mag << FRAC) / den;
        lim = 64'((num < 0) ? fmd_pkg::OUT_MAX_NEG : fmd_pkg::OUT_MAX_POS);
        if (quo > lim) begin
          quo      = lim;
          want.sat = 1'b1;
        end
        want.value = OUT_W'((num < 0) ? -quo : quo);
      end
      want_q = {want_q, want};
    endfunction

    function void check_result(logic signed [OUT_W-1:0] value, logic sat);
      demod_t want;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: demod_value=%0d saturated=%0b", value, sat);
      end else begin
        want = want_q.pop_front();
        if (value !== want.value || sat !== want.sat) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch for I=%0d Q=%0d: expected %0d/%0b, got %0d/%0b",
                     want.i_s, want.q_s, want.value, want.sat, value, sat);
        end
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  fmd_in_if #(.SAMPLE_WIDTH(SW)) in_ch ();
  fmd_out_if                     out_ch ();

  fm_discriminator_core #(
    .SAMPLE_WIDTH (SW),
    .OUT_FRAC_BITS(FRAC)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  demod_scoreboard scoreboard = new();

  int      tx_idle_pct;
  int      rx_idle_pct;
  logic    holdoff_req;
  int      holdoff_left;
  sample_t last_tx_i;
  sample_t last_tx_q;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  initial begin
    #(CLK_HALF * 2 * TIMEOUT_CYCLES);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: check every accepted beat, then pick ready for the next edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        scoreboard.check_result(out_ch.demod_value, out_ch.saturated);
      if (holdoff_req) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_req  = 1'b0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Valid stays high from one beat to the next unless an idle cycle is drawn.
  task automatic send_pair(sample_t i_s, sample_t q_s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.i_sample <= i_s;
    in_ch.q_sample <= q_s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    scoreboard.note_pair(i_s, q_s);
    last_tx_i = i_s;
    last_tx_q = q_s;
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
  endtask

  // Most beats follow a slowly rotating phasor so the discriminator sees
  // realistic frequency values; the rest are noise, zeros, tiny vectors
  // and full-scale corners.
  task automatic send_random(int count);
    int      pick, k, wi, wq, di, dq;
    sample_t ri, rq;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        k  = $urandom_range(8, 2);
        di = int'(last_tx_q) >>> k;
        dq = int'(last_tx_i) >>> k;
        if ($urandom_range(1)) begin
          di = -di;
          dq = -dq;
        end
        wi = int'(last_tx_i) - di;
        wq = int'(last_tx_q) + dq;
        if (wi > 30000 || wi < -30000 || wq > 30000 || wq < -30000) begin
          wi = wi / 2;
          wq = wq / 2;
        end
        if (wi < 64 && wi > -64 && wq < 64 && wq > -64) begin
          wi = int'($urandom_range(40000)) - 20000;
          wq = int'($urandom_range(40000)) - 20000;
        end
        ri = SW'(wi);
        rq = SW'(wq);
      end else if (pick < 75) begin
        ri = SW'($urandom);
        rq = SW'($urandom);
      end else if (pick < 85) begin
        ri = SW'($urandom);
        rq = SW'($urandom);
        case ($urandom_range(2))
          0:       ri = '0;
          1:       rq = '0;
          default: begin
            ri = '0;
            rq = '0;
          end
        endcase
      end else if (pick < 95) begin
        ri = SW'(int'($urandom_range(8)) - 4);
        rq = SW'(int'($urandom_range(8)) - 4);
      end else begin
        case ($urandom_range(5))
          0:       ri = sample_t'(-32768);
          1:       ri = sample_t'(-32767);
          2:       ri = sample_t'(-1);
          3:       ri = sample_t'(1);
          4:       ri = sample_t'(32766);
          default: ri = sample_t'(32767);
        endcase
        rq = $urandom_range(1) ? sample_t'(-32768) : sample_t'(32767);
      end
      send_pair(ri, rq);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.i_sample = '0;
    in_ch.q_sample = '0;
    out_ch.ready   = 1'b0;
    holdoff_req    = 1'b0;
    holdoff_left   = 0;
    last_tx_i      = '0;
    last_tx_q      = '0;
    tx_idle_pct    = 12;
    rx_idle_pct    = 66;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Full-scale corners first; the previous pair is zero
    // after reset, so the very first result is zero.
    send_pair(sample_t'(32767), sample_t'(32767));
    send_pair(sample_t'(-32768), sample_t'(-32768));
    send_pair(sample_t'(32767), sample_t'(-32768));
    send_pair(sample_t'(-32768), sample_t'(32767));
    // Zero I, zero Q and both zero.
    send_pair(sample_t'(0), sample_t'(12345));
    send_pair(sample_t'(-4321), sample_t'(0));
    send_pair(sample_t'(0), sample_t'(0));
    // Quotient of exactly -8.0 lands on the negative end without clipping.
    send_pair(sample_t'(0), sample_t'(16));
    send_pair(sample_t'(1), sample_t'(1));
    // Quotient of +8.0 is one past the positive end and clips.
    send_pair(sample_t'(16), sample_t'(0));
    send_pair(sample_t'(1), sample_t'(1));
    // A quarter and a half turn of a unit vector, then tiny against full-scale values.
    send_pair(sample_t'(-1), sample_t'(1));
    send_pair(sample_t'(1), sample_t'(-1));
    send_pair(sample_t'(-32768), sample_t'(1));
    send_pair(sample_t'(1), sample_t'(-32768));
    send_pair(sample_t'(-1), sample_t'(-1));
    // Alternating bit patterns in both fields.
    send_pair(16'sh5555, 16'shAAAA);
    send_pair(16'shAAAA, 16'sh5555);
    send_pair(sample_t'(-2), sample_t'(3));
    send_pair(sample_t'(3), sample_t'(2));
    send_pair(sample_t'(20000), sample_t'(-7));

    send_random(PHASE_ITEMS);

    tx_idle_pct = 66;
    rx_idle_pct = 12;
    send_random(PHASE_ITEMS);

    // Let the pipeline empty completely before the back-to-back phase.
    wait_for_results();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // The receiver holds off long enough for the core to fill up and drop
    // its input ready while beats keep being offered.
    holdoff_req = 1'b1;
    send_random(PHASE_ITEMS + 10);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (scoreboard.mismatches == 0 && scoreboard.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
